// ===== hdl/rme_pkg.sv =====
`default_nettype none
package rme_pkg;

    localparam int CordicStages = 16;
    localparam int CordicW = 28;
    localparam int AngW = 27;
    localparam int SqrtSteps = 15;

    localparam logic signed [AngW-1:0] HalfPiFine = 27'sd26353589;
    localparam logic signed [15:0] OutPi = 16'sd25736;
    localparam logic signed [15:0] OutHalfPi = 16'sd12868;
    localparam logic [14:0] ThreshReset = 15'd16351;

    typedef enum logic [1:0]
    {
        POLE_NONE  = 2'd0,
        POLE_NORTH = 2'd1,
        POLE_SOUTH = 2'd2
    } pole_t;

    typedef struct packed
    {
        logic signed [CordicW-1:0] x;
        logic signed [CordicW-1:0] y;
        logic signed [AngW-1:0] z;
        logic zero;
    } cordic_t;

    typedef struct packed
    {
        logic [29:0] rem;
        logic [14:0] root;
        logic signed [15:0] s;
    } sqrt_t;

    function automatic logic signed [AngW-1:0] atan_entry(input int i);
        logic signed [AngW-1:0] r;
        begin
            case (i)
                0: r = 27'sd13176795;
                1: r = 27'sd7778716;
                2: r = 27'sd4110060;
                3: r = 27'sd2086331;
                4: r = 27'sd1047214;
                5: r = 27'sd524117;
                6: r = 27'sd262123;
                7: r = 27'sd131069;
                default: r = (i < 25) ? AngW'(27'sd65536 >>> (i - 8)) : '0;
            endcase
            return r;
        end
    endfunction

    function automatic cordic_t cordic_init(input logic signed [16:0] a,
                                            input logic signed [16:0] b);
        cordic_t c;
        logic signed [CordicW-1:0] y;
        logic signed [CordicW-1:0] x;
        begin
            y = CordicW'(a) <<< 8;
            x = CordicW'(b) <<< 8;
            c.zero = (a == 0) && (b == 0);
            c.z = '0;
            c.x = x;
            c.y = y;
            if (x < 0)
            begin
                if (y >= 0)
                begin
                    c.x = y;
                    c.y = -x;
                    c.z = HalfPiFine;
                end
                else
                begin
                    c.x = -y;
                    c.y = x;
                    c.z = -HalfPiFine;
                end
            end
            return c;
        end
    endfunction

    function automatic logic signed [15:0] to_out(input cordic_t c);
        logic signed [AngW-1:0] r;
        logic signed [15:0] o;
        begin
            r = (c.z + AngW'(1024)) >>> 11;
            if (r > AngW'(OutPi))
                o = OutPi;
            else if (r < -AngW'(OutPi))
                o = -OutPi;
            else
                o = r[15:0];
            if (c.zero)
                o = '0;
            return o;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rme_cordic_cell.sv =====
`default_nettype none
module rme_cordic_cell
    import rme_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire logic [4:0] stage,
    input  wire cordic_t d,
    output cordic_t q
);

    cordic_t q_reg;
    cordic_t q_next;
    logic signed [CordicW-1:0] dx;
    logic signed [CordicW-1:0] dy;
    logic signed [AngW-1:0] t;

    always_comb
    begin
        dx = d.y >>> stage;
        dy = d.x >>> stage;
        t = atan_entry(int'(stage));
        q_next = d;
        if (d.y >= 0)
        begin
            q_next.x = d.x + dx;
            q_next.y = d.y - dy;
            q_next.z = d.z + t;
        end
        else
        begin
            q_next.x = d.x - dx;
            q_next.y = d.y + dy;
            q_next.z = d.z - t;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ===== hdl/rme_sqrt_cell.sv =====
`default_nettype none
module rme_sqrt_cell
    import rme_pkg::*;
(
    input  wire logic clk,
    input  wire logic en,
    input  wire logic [3:0] step,
    input  wire sqrt_t d,
    output sqrt_t q
);

    sqrt_t q_reg;
    sqrt_t q_next;
    logic [29:0] trial;
    logic [4:0] sh;

    always_comb
    begin
        sh = 5'(step) << 1;
        trial = ({15'd0, d.root} << 2 | 30'd1) << sh;
        q_next = d;
        q_next.root = d.root << 1;
        if (d.rem >= trial)
        begin
            q_next.rem = d.rem - trial;
            q_next.root = (d.root << 1) | 15'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            q_reg <= q_next;
    end

    assign q = q_reg;

endmodule
`default_nettype wire

// ===== hdl/rotation_matrix_to_euler.sv =====
// Converts seven entries of a rotation matrix (signed Q2.14) into three Euler
// angles in signed Q3.13 radians plus a pole-case code. The block accepts one
// item every cycle while the output is not stalled. Each item passes through 16
// register stages in the square-root cell chain (the input register and 15 cells)
// and 18 in the CORDIC cell chain (the seeding register, 16 cells and the output
// register). The whole pipeline advances only when its output register is free
// or being read, so backpressure stalls every cell together.
`default_nettype none
module rotation_matrix_to_euler
    import rme_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_valid,
    output logic cfg_ready,
    input  wire logic [14:0] cfg_data,
    input  wire logic s_axis_tvalid,
    output logic s_axis_tready,
    // elem_r0c0, elem_r0c2, elem_r1c0, elem_r1c1, elem_r1c2, elem_r2c0, elem_r2c2
    input  wire logic [111:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  wire logic m_axis_tready,
    // first_angle, second_angle, third_angle
    output logic [47:0] m_axis_tdata,
    // pole_case
    output logic [1:0] m_axis_tuser
);

    localparam int Depth = SqrtSteps + CordicStages + 3;

    logic [14:0] thr_reg;
    logic [Depth-1:0] vld_reg;
    logic adv;
    logic signed [15:0] r00, r02, r10, r11, r12, r20, r22;
    logic signed [15:0] sc;
    pole_t pole_in;

    sqrt_t sq [0:SqrtSteps];
    logic signed [15:0] b_x [0:SqrtSteps];
    logic signed [15:0] b_z [0:SqrtSteps];
    pole_t pl [0:SqrtSteps];

    cordic_t cx [0:CordicStages];
    cordic_t cy [0:CordicStages];
    cordic_t cz [0:CordicStages];
    pole_t pc [0:CordicStages];

    logic signed [15:0] o1_reg, o2_reg, o3_reg;
    pole_t op_reg;

    assign cfg_ready = 1'b1;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[Depth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= ThreshReset;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[Depth-2:0], s_axis_tvalid};
    end

    always_comb
    begin
        r00 = s_axis_tdata[15:0];
        r02 = s_axis_tdata[31:16];
        r10 = s_axis_tdata[47:32];
        r11 = s_axis_tdata[63:48];
        r12 = s_axis_tdata[79:64];
        r20 = s_axis_tdata[95:80];
        r22 = s_axis_tdata[111:96];
        if (17'(r10) > $signed({2'b0, thr_reg}))
            pole_in = POLE_NORTH;
        else if (17'(r10) < -$signed({2'b0, thr_reg}))
            pole_in = POLE_SOUTH;
        else
            pole_in = POLE_NONE;
        sc = r10;
        if (r10 > 16'sd16384)
            sc = 16'sd16384;
        if (r10 < -16'sd16384)
            sc = -16'sd16384;
    end

    // Entry 0 of each line is the input register stage.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq[0].rem <= 30'd268435456 - 30'(32'(sc) * 32'(sc));
            sq[0].root <= '0;
            sq[0].s <= sc;
            pl[0] <= pole_in;
            if (pole_in == POLE_NONE)
            begin
                b_x[0] <= r11;
                b_z[0] <= r00;
            end
            else
            begin
                b_x[0] <= '0;
                b_z[0] <= r22;
            end
        end
    end

    // Negating r12 or r20 of -32768 must stay positive, so the first arguments
    // travel on a 17-bit path.
    logic signed [16:0] ax17 [0:SqrtSteps];
    logic signed [16:0] az17 [0:SqrtSteps];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax17[0] <= (pole_in == POLE_NONE) ? -17'(r12) : 17'sd0;
            az17[0] <= (pole_in == POLE_NONE) ? -17'(r20) : 17'(r02);
        end
    end

    genvar g;
    generate
        for (g = 0; g < SqrtSteps; g++)
        begin : g_sqrt
            rme_sqrt_cell u_cell
            (
                .clk(clk),
                .en(adv),
                .step(4'(SqrtSteps - 1 - g)),
                .d(sq[g]),
                .q(sq[g+1])
            );

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    b_x[g+1] <= b_x[g];
                    b_z[g+1] <= b_z[g];
                    ax17[g+1] <= ax17[g];
                    az17[g+1] <= az17[g];
                    pl[g+1] <= pl[g];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx[0] <= cordic_init(ax17[SqrtSteps], 17'(b_x[SqrtSteps]));
            cy[0] <= cordic_init(17'(sq[SqrtSteps].s), {2'b0, sq[SqrtSteps].root});
            cz[0] <= cordic_init(az17[SqrtSteps], 17'(b_z[SqrtSteps]));
            pc[0] <= pl[SqrtSteps];
        end
    end

    generate
        for (g = 0; g < CordicStages; g++)
        begin : g_cordic
            rme_cordic_cell u_x
            (
                .clk(clk),
                .en(adv),
                .stage(5'(g)),
                .d(cx[g]),
                .q(cx[g+1])
            );
            rme_cordic_cell u_y
            (
                .clk(clk),
                .en(adv),
                .stage(5'(g)),
                .d(cy[g]),
                .q(cy[g+1])
            );
            rme_cordic_cell u_z
            (
                .clk(clk),
                .en(adv),
                .stage(5'(g)),
                .d(cz[g]),
                .q(cz[g+1])
            );

            always_ff @(posedge clk)
            begin
                if (adv)
                    pc[g+1] <= pc[g];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o3_reg <= to_out(cz[CordicStages]);
            op_reg <= pc[CordicStages];
            case (pc[CordicStages])
                POLE_NORTH:
                begin
                    o1_reg <= '0;
                    o2_reg <= OutHalfPi;
                end
                POLE_SOUTH:
                begin
                    o1_reg <= '0;
                    o2_reg <= -OutHalfPi;
                end
                default:
                begin
                    o1_reg <= -to_out(cx[CordicStages]);
                    o2_reg <= to_out(cy[CordicStages]);
                end
            endcase
        end
    end

    assign m_axis_tdata = {o3_reg, o2_reg, o1_reg};
    assign m_axis_tuser = op_reg;

endmodule
`default_nettype wire
